/* sv/x12st_pkg.sv */
`default_nettype none

package x12st_pkg;

  localparam int HEADER_BYTES    = 106;
  localparam int MAX_ELEMENTS    = 32;
  localparam int ELM_DELIM_INDEX = 103;
  localparam int SEG_DELIM_INDEX = 105;
  localparam int TYPE_BYTES      = 4;

  localparam int CNT_W   = $clog2(HEADER_BYTES + 1);
  localparam int ELCNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int TYPE_W  = 8 * TYPE_BYTES;
  localparam int ELEM_W  = 5;
  localparam int OFF_W   = 16;

  typedef enum logic [1:0] {
    KIND_ELEMENT = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_EOF     = 2'd2,
    KIND_INVALID = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic                valid;
    event_kind_e         kind;
    logic [TYPE_W-1:0]   seg_type;
    logic [ELEM_W-1:0]   elem_num;
    logic [OFF_W-1:0]    offset;
  } tok_event_t;

endpackage

`default_nettype wire

/* sv/x12st_line.sv */
`default_nettype none

module x12st_line import x12st_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] fill_i,
  output logic      [7:0] oldest_o,
  output logic      [7:0] elm_tap_o
);

  localparam int ElmTap = ELM_DELIM_INDEX + 1;

  logic [7:0] line_q [HEADER_BYTES];

  // New bytes enter at the top and move one place toward index zero per shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[HEADER_BYTES-1] <= fill_i;
    end
  end

  assign oldest_o  = line_q[0];
  assign elm_tap_o = line_q[ElmTap];

endmodule

`default_nettype wire

/* sv/x12st_tok.sv */
`default_nettype none

module x12st_tok import x12st_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       command_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] oldest_i,
  input  wire logic [7:0] elm_tap_i,
  output logic            shift_o,
  output logic      [7:0] fill_o,
  output tok_event_t      event_o
);

  typedef enum logic [1:0] {
    PH_FILL    = 2'd0,
    PH_STREAM  = 2'd1,
    PH_EOF     = 2'd2,
    PH_INVALID = 2'd3
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   bytes_seen_q, bytes_seen_d;
  logic [CNT_W-1:0]   drain_count_q, drain_count_d;
  logic [7:0]         elm_delim_q, elm_delim_d;
  logic [7:0]         seg_delim_q, seg_delim_d;
  logic [OFF_W-1:0]   pos_q, pos_d;
  logic [TYPE_W-1:0]  acc_q, acc_d;
  logic [ELCNT_W-1:0] count_q, count_d;

  logic [OFF_W-1:0]   pos_inc;
  logic [ELCNT_W-1:0] count_inc;
  logic [TYPE_W-1:0]  acc_merged;
  tok_event_t         tok_ev;
  logic [OFF_W-1:0]   tok_pos;
  logic [TYPE_W-1:0]  tok_acc;
  logic [ELCNT_W-1:0] tok_count;

  assign pos_inc   = (pos_q == {OFF_W{1'b1}}) ? pos_q : pos_q + OFF_W'(1);
  assign count_inc = count_q + ELCNT_W'(1);

  always_comb begin
    acc_merged = acc_q;
    for (int i = 0; i < TYPE_BYTES; i++) begin
      if (pos_q == OFF_W'(i)) begin
        acc_merged[8*i +: 8] = acc_q[8*i +: 8] | oldest_i;
      end
    end
  end

  // Tokenizer result for the byte leaving the delay line.
  always_comb begin
    tok_ev          = '0;
    tok_ev.valid    = 1'b0;
    tok_ev.kind     = KIND_ELEMENT;
    tok_pos         = pos_inc;
    tok_acc         = acc_q;
    tok_count       = count_q;
    if (oldest_i == elm_delim_q) begin
      tok_ev.valid    = 1'b1;
      tok_ev.kind     = KIND_ELEMENT;
      tok_ev.seg_type = acc_q;
      tok_ev.elem_num = ELEM_W'(count_q);
      tok_ev.offset   = pos_q;
      if (count_inc >= ELCNT_W'(MAX_ELEMENTS)) begin
        tok_pos   = '0;
        tok_acc   = '0;
        tok_count = '0;
      end else begin
        tok_count = count_inc;
      end
    end else if (oldest_i == seg_delim_q) begin
      tok_ev.valid    = 1'b1;
      tok_ev.kind     = KIND_SEGMENT;
      tok_ev.seg_type = acc_q;
      tok_ev.elem_num = ELEM_W'(count_q);
      tok_ev.offset   = pos_q;
      tok_pos         = '0;
      tok_acc         = '0;
      tok_count       = '0;
    end else if (pos_q < OFF_W'(TYPE_BYTES) && count_q == '0) begin
      tok_acc = acc_merged;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    bytes_seen_d  = bytes_seen_q;
    drain_count_d = drain_count_q;
    elm_delim_d   = elm_delim_q;
    seg_delim_d   = seg_delim_q;
    pos_d         = pos_q;
    acc_d         = acc_q;
    count_d       = count_q;
    shift_o       = 1'b0;
    fill_o        = command_i ? 8'h00 : data_byte_i;
    event_o       = '0;
    event_o.kind  = KIND_ELEMENT;
    if (step_i) begin
      if (!command_i) begin
        case (phase_q)
          PH_FILL: begin
            shift_o      = 1'b1;
            bytes_seen_d = bytes_seen_q + CNT_W'(1);
            if (bytes_seen_q == CNT_W'(HEADER_BYTES - 1)) begin
              elm_delim_d = elm_tap_i;
              seg_delim_d = data_byte_i;
              phase_d     = PH_STREAM;
            end
          end
          PH_STREAM: begin
            if (drain_count_q == '0) begin
              shift_o = 1'b1;
              event_o = tok_ev;
              pos_d   = tok_pos;
              acc_d   = tok_acc;
              count_d = tok_count;
            end
          end
          default: begin
          end
        endcase
      end else begin
        case (phase_q)
          PH_FILL: begin
            phase_d       = PH_INVALID;
            event_o.valid = 1'b1;
            event_o.kind  = KIND_INVALID;
          end
          PH_STREAM: begin
            if (drain_count_q < CNT_W'(HEADER_BYTES)) begin
              drain_count_d = drain_count_q + CNT_W'(1);
              shift_o       = 1'b1;
              event_o       = tok_ev;
              pos_d         = tok_pos;
              acc_d         = tok_acc;
              count_d       = tok_count;
            end else if (pos_q != '0) begin
              event_o.valid    = 1'b1;
              event_o.kind     = KIND_SEGMENT;
              event_o.seg_type = acc_q;
              event_o.elem_num = ELEM_W'(count_q);
              event_o.offset   = pos_q;
              pos_d            = '0;
              acc_d            = '0;
              count_d          = '0;
            end else begin
              phase_d       = PH_EOF;
              event_o.valid = 1'b1;
              event_o.kind  = KIND_EOF;
            end
          end
          PH_EOF: begin
            event_o.valid = 1'b1;
            event_o.kind  = KIND_EOF;
          end
          default: begin
            event_o.valid = 1'b1;
            event_o.kind  = KIND_INVALID;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FILL;
      bytes_seen_q  <= '0;
      drain_count_q <= '0;
      elm_delim_q   <= '0;
      seg_delim_q   <= '0;
      pos_q         <= '0;
      acc_q         <= '0;
      count_q       <= '0;
    end else begin
      phase_q       <= phase_d;
      bytes_seen_q  <= bytes_seen_d;
      drain_count_q <= drain_count_d;
      elm_delim_q   <= elm_delim_d;
      seg_delim_q   <= seg_delim_d;
      pos_q         <= pos_d;
      acc_q         <= acc_d;
      count_q       <= count_d;
    end
  end

endmodule

`default_nettype wire

/* sv/x12_segment_tokenizer.sv */
// Streaming tokenizer for X12 EDI files, one file byte per transaction.
// Slave channel: tuser is the command (0 file byte, 1 drain step), tdata the byte.
// Master channel: tuser is the event kind (element delimiter, segment end,
// end of file, invalid file); tdata carries segment type, element number and
// the delimiter offset within the segment.
// The first 106 bytes fill the header delay line and give no events; the
// delimiters come from bytes 103 and 105 of the header. After that each byte
// pushes the oldest one out, and that byte is tokenized. Send one drain step
// per byte still in the line, then further drain steps to close the last
// segment and to get end of file.
// Throughput is one transaction per cycle while the receiver takes results: each
// byte needs one compare pair and a counter update. An event appears on the master
// side in the cycle after the transaction that causes it, from a single result register.
// When the receiver stalls with a result waiting, s_axis_tready drops until
// that result is taken. Reset clears the tokenizer counters, the delimiters and
// the result valid flag; the header bytes refill the delay line before it is read.
`default_nettype none

module x12_segment_tokenizer import x12st_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic  [7:0] s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,  // [31:0] segment_type, [36:32] element_number,
                                          // [52:37] byte_offset, [55:53] zero
  output logic       [1:0] m_axis_tuser   // [1:0] event_kind
);

  logic       accept;
  logic       shift;
  logic [7:0] fill;
  logic [7:0] oldest;
  logic [7:0] elm_tap;
  tok_event_t tok_ev;

  logic              out_valid_q, out_valid_d;
  event_kind_e       out_kind_q;
  logic [TYPE_W-1:0] out_type_q;
  logic [ELEM_W-1:0] out_elem_q;
  logic [OFF_W-1:0]  out_off_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  x12st_line u_line (
    .clk_i     (clk_i),
    .shift_i   (shift),
    .fill_i    (fill),
    .oldest_o  (oldest),
    .elm_tap_o (elm_tap)
  );

  x12st_tok u_tok (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .oldest_i    (oldest),
    .elm_tap_i   (elm_tap),
    .shift_o     (shift),
    .fill_o      (fill),
    .event_o     (tok_ev)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = tok_ev.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tok_ev.valid) begin
      out_kind_q <= tok_ev.kind;
      out_type_q <= tok_ev.seg_type;
      out_elem_q <= tok_ev.elem_num;
      out_off_q  <= tok_ev.offset;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {3'b000, out_off_q, out_elem_q, out_type_q};

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a waiting result");

  a_no_result_without_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without an input transaction");

  a_file_events_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_EOF || m_axis_tuser == KIND_INVALID)
      |-> m_axis_tdata == '0)
    else $error("end of file or invalid file event with nonzero payload");

endmodule

`default_nettype wire
